### sv/alcf_pkg.sv
// Shared types, constants and helper functions for the chain follow unit.
package alcf_pkg;

    localparam int NUM_SEGMENTS = 10;
    localparam int ANGLE_BITS   = 16;
    localparam int CORDIC_STEPS = 24;
    localparam int SEG_W        = $clog2(NUM_SEGMENTS);
    localparam int STEP_W       = $clog2(CORDIC_STEPS);
    localparam int COORD_W      = 21;
    localparam int CW           = 48;

    localparam logic signed [COORD_W-1:0] COORD_MAX = 21'sd1048575;
    localparam logic signed [COORD_W-1:0] COORD_MIN = -21'sd1048576;
    localparam logic [31:0] CORDIC_GAIN_Q32 = 32'd2608131496;

    localparam logic [3:0] REG_SPACING = 4'd0;
    localparam logic [3:0] REG_NECK    = 4'd1;
    localparam logic [3:0] REG_SPINE   = 4'd2;
    localparam logic [3:0] REG_GAIN    = 4'd3;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_HEAD_MUL,
        ST_HEAD_ADD,
        ST_HEAD_OUT,
        ST_BEAR_INIT,
        ST_BEAR_RUN,
        ST_BEND,
        ST_ROT_MUL,
        ST_ROT_INIT,
        ST_ROT_RUN,
        ST_PLACE,
        ST_SEG_OUT
    } state_t;

    typedef struct packed {
        logic             load_item;
        logic             head_mul;
        logic             head_add;
        logic             bear_init;
        logic             rot_mul;
        logic             rot_init;
        logic             cordic_step;
        logic             do_bend;
        logic             place;
        logic             out_load;
        logic             out_head;
        logic [SEG_W-1:0] seg;
        logic [STEP_W-1:0] step;
    } cmd_t;

    function automatic logic [31:0] cordic_atan(input logic [STEP_W-1:0] i);
        logic [31:0] r;
        begin
            unique case (i)
                5'd0:  r = 32'h20000000;
                5'd1:  r = 32'h12E4051E;
                5'd2:  r = 32'h09FB385B;
                5'd3:  r = 32'h051111D4;
                5'd4:  r = 32'h028B0D43;
                5'd5:  r = 32'h0145D7E1;
                5'd6:  r = 32'h00A2F61E;
                5'd7:  r = 32'h00517C55;
                5'd8:  r = 32'h0028BE53;
                5'd9:  r = 32'h00145F2F;
                5'd10: r = 32'h000A2F98;
                5'd11: r = 32'h000517CC;
                5'd12: r = 32'h00028BE6;
                5'd13: r = 32'h000145F3;
                5'd14: r = 32'h0000A2F9;
                5'd15: r = 32'h0000517D;
                5'd16: r = 32'h000028BE;
                5'd17: r = 32'h0000145F;
                5'd18: r = 32'h00000A30;
                5'd19: r = 32'h00000518;
                5'd20: r = 32'h0000028C;
                5'd21: r = 32'h00000146;
                5'd22: r = 32'h000000A3;
                5'd23: r = 32'h00000051;
                default: r = 32'h0;
            endcase
            return r;
        end
    endfunction

    function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [CW-1:0] v);
        logic signed [COORD_W-1:0] r;
        begin
            if (v > CW'(COORD_MAX))
                r = COORD_MAX;
            else if (v < CW'(COORD_MIN))
                r = COORD_MIN;
            else
                r = v[COORD_W-1:0];
            return r;
        end
    endfunction

endpackage

### sv/alcf_ctrl.sv
// Controller state machine sequencing head update and per-segment CORDIC work.
module alcf_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             valid,
    output logic             ready,
    input  logic             point_valid,
    input  logic             point_ready,
    input  logic             jump_flag,
    output alcf_pkg::cmd_t   cmd
);

    alcf_pkg::state_t state_reg, state_next;
    logic [alcf_pkg::SEG_W-1:0]  seg_reg, seg_next;
    logic [alcf_pkg::STEP_W-1:0] step_reg, step_next;
    logic out_free;

    assign out_free = !point_valid || point_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= alcf_pkg::ST_IDLE;
            seg_reg   <= '0;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            seg_reg   <= seg_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        seg_next   = seg_reg;
        step_next  = step_reg;
        cmd        = '0;
        cmd.seg    = seg_reg;
        cmd.step   = step_reg;
        ready      = 1'b0;
        unique case (state_reg)
            alcf_pkg::ST_IDLE:
            begin
                ready = 1'b1;
                if (valid)
                begin
                    cmd.load_item = 1'b1;
                    seg_next      = '0;
                    state_next    = alcf_pkg::ST_HEAD_MUL;
                end
            end
            alcf_pkg::ST_HEAD_MUL:
            begin
                cmd.head_mul = 1'b1;
                state_next   = alcf_pkg::ST_HEAD_ADD;
            end
            alcf_pkg::ST_HEAD_ADD:
            begin
                cmd.head_add = 1'b1;
                state_next   = alcf_pkg::ST_HEAD_OUT;
            end
            alcf_pkg::ST_HEAD_OUT:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_head = 1'b1;
                    state_next   = alcf_pkg::ST_BEAR_INIT;
                end
            end
            alcf_pkg::ST_BEAR_INIT:
            begin
                cmd.bear_init = 1'b1;
                step_next     = '0;
                state_next    = alcf_pkg::ST_BEAR_RUN;
            end
            alcf_pkg::ST_BEAR_RUN:
            begin
                cmd.cordic_step = 1'b1;
                step_next       = step_reg + 1'b1;
                if (step_reg == alcf_pkg::STEP_W'(alcf_pkg::CORDIC_STEPS - 1))
                    state_next = alcf_pkg::ST_BEND;
            end
            alcf_pkg::ST_BEND:
            begin
                cmd.do_bend = 1'b1;
                state_next  = alcf_pkg::ST_ROT_MUL;
            end
            alcf_pkg::ST_ROT_MUL:
            begin
                cmd.rot_mul = 1'b1;
                state_next  = alcf_pkg::ST_ROT_INIT;
            end
            alcf_pkg::ST_ROT_INIT:
            begin
                cmd.rot_init = 1'b1;
                step_next    = '0;
                state_next   = alcf_pkg::ST_ROT_RUN;
            end
            alcf_pkg::ST_ROT_RUN:
            begin
                cmd.cordic_step = 1'b1;
                step_next       = step_reg + 1'b1;
                if (step_reg == alcf_pkg::STEP_W'(alcf_pkg::CORDIC_STEPS - 1))
                    state_next = alcf_pkg::ST_PLACE;
            end
            alcf_pkg::ST_PLACE:
            begin
                cmd.place  = 1'b1;
                state_next = alcf_pkg::ST_SEG_OUT;
            end
            alcf_pkg::ST_SEG_OUT:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    seg_next     = seg_reg + 1'b1;
                    if (seg_reg == alcf_pkg::SEG_W'(alcf_pkg::NUM_SEGMENTS - 1))
                        state_next = alcf_pkg::ST_IDLE;
                    else
                        state_next = alcf_pkg::ST_BEAR_INIT;
                end
            end
            default:
                state_next = alcf_pkg::ST_IDLE;
        endcase
        if (state_reg == alcf_pkg::ST_HEAD_MUL && jump_flag)
        begin
            cmd.head_mul = 1'b0;
            state_next   = alcf_pkg::ST_HEAD_OUT;
        end
    end

endmodule

### sv/alcf_datapath.sv
// Datapath: head smoothing, shared CORDIC, bend clamp, chain storage and output register.
module alcf_datapath (
    input  logic                clk,
    input  logic                rst_n,
    input  alcf_pkg::cmd_t      cmd,
    input  logic                cfg_we,
    input  logic [3:0]          cfg_index,
    input  logic [14:0]         cfg_data,
    input  logic signed [20:0]  target_x,
    input  logic signed [20:0]  target_y,
    input  logic [15:0]         heading,
    input  logic                jump,
    output logic                jump_flag,
    output logic [3:0]          point_index,
    output logic signed [20:0]  point_x,
    output logic signed [20:0]  point_y,
    output logic [15:0]         point_direction,
    output logic                last,
    output logic                point_valid,
    input  logic                point_ready
);

    localparam int CW = alcf_pkg::CW;
    localparam int AB = alcf_pkg::ANGLE_BITS;
    localparam int N  = alcf_pkg::NUM_SEGMENTS;
    localparam int SW = alcf_pkg::SEG_W;

    logic [7:0]  spacing_reg;
    logic [14:0] neck_lim_reg, spine_lim_reg;
    logic [8:0]  gain_reg;

    logic signed [20:0] tx_reg, ty_reg, hx_reg, hy_reg;
    logic [AB-1:0]      heading_reg;
    logic               jump_reg;
    logic signed [CW-1:0] mx_reg, my_reg;

    logic signed [20:0] cx_reg [N];
    logic signed [20:0] cy_reg [N];
    logic signed [20:0] px_reg, py_reg;
    logic [AB-1:0]      pdir_reg, dir_reg;
    logic [14:0]        lim_reg;

    logic signed [CW-1:0] x_reg, y_reg;
    logic [31:0]          z_reg;
    logic                 rot_mode_reg, flip_reg, zero_reg;
    logic [55:0]          scale_reg;

    logic signed [CW-1:0] x_sh, y_sh, x_nx, y_nx;
    logic [31:0]          z_nx, turn;
    logic                 go_pos;

    logic signed [CW-1:0] dxw, dyw;
    logic [31:0]          zr;
    logic signed [32:0]   zs;
    logic [AB-1:0]        bearing_w, dir_w, diff_w;
    logic signed [AB:0]   d_w;
    logic signed [CW-1:0] ox_w, oy_w, ox_f, oy_f;

    assign jump_flag = jump_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spacing_reg   <= 8'd35;
            neck_lim_reg  <= 15'd3095;
            spine_lim_reg <= 15'd5643;
            gain_reg      <= 9'd51;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                alcf_pkg::REG_SPACING: spacing_reg   <= cfg_data[7:0];
                alcf_pkg::REG_NECK:    neck_lim_reg  <= cfg_data;
                alcf_pkg::REG_SPINE:   spine_lim_reg <= cfg_data;
                alcf_pkg::REG_GAIN:    gain_reg      <= cfg_data[8:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        turn   = alcf_pkg::cordic_atan(cmd.step);
        x_sh   = x_reg >>> cmd.step;
        y_sh   = y_reg >>> cmd.step;
        go_pos = rot_mode_reg ? !z_reg[31] : (y_reg > 0);
        if (rot_mode_reg ? go_pos : !go_pos)
        begin
            x_nx = x_reg - y_sh;
            y_nx = y_reg + x_sh;
        end
        else
        begin
            x_nx = x_reg + y_sh;
            y_nx = y_reg - x_sh;
        end
        z_nx = (rot_mode_reg ? !go_pos : go_pos) ? z_reg + turn : z_reg - turn;

        dxw = (CW'(px_reg) - CW'(cx_reg[cmd.seg])) <<< 8;
        dyw = (CW'(py_reg) - CW'(cy_reg[cmd.seg])) <<< 8;

        zr        = z_reg + (32'd1 << (31 - AB));
        bearing_w = zero_reg ? '0 : zr[31 -: AB];
        diff_w    = bearing_w - pdir_reg;
        d_w       = (diff_w > (AB'(1) << (AB - 1))) ? {1'b1, diff_w} : {1'b0, diff_w};
        if (d_w > $signed({2'b00, lim_reg}))
            d_w = $signed({2'b00, lim_reg});
        else if (d_w < -$signed({2'b00, lim_reg}))
            d_w = -$signed({2'b00, lim_reg});
        dir_w = pdir_reg + d_w[AB-1:0];

        zs = {1'b0, dir_reg, {(32 - AB){1'b0}}};
        if (zs[31])
            zs = zs - 33'sh100000000;

        ox_w = (x_reg + CW'(32768)) >>> 16;
        oy_w = (y_reg + CW'(32768)) >>> 16;
        ox_f = flip_reg ? -ox_w : ox_w;
        oy_f = flip_reg ? -oy_w : oy_w;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_item)
        begin
            tx_reg      <= target_x;
            ty_reg      <= target_y;
            heading_reg <= heading[AB-1:0];
            jump_reg    <= jump;
        end
        if (cmd.head_mul)
        begin
            mx_reg <= (CW'(tx_reg) - CW'(hx_reg)) * $signed({1'b0, gain_reg}) + CW'(128);
            my_reg <= (CW'(ty_reg) - CW'(hy_reg)) * $signed({1'b0, gain_reg}) + CW'(128);
        end
        if (cmd.out_load && cmd.out_head)
        begin
            px_reg   <= hx_reg;
            py_reg   <= hy_reg;
            pdir_reg <= heading_reg;
            lim_reg  <= neck_lim_reg;
        end
        if (cmd.bear_init)
        begin
            rot_mode_reg <= 1'b0;
            zero_reg     <= (dxw == 0) && (dyw == 0);
            if (dxw < 0)
            begin
                x_reg <= -dxw;
                y_reg <= -dyw;
                z_reg <= 32'h80000000;
            end
            else
            begin
                x_reg <= dxw;
                y_reg <= dyw;
                z_reg <= 32'h0;
            end
        end
        if (cmd.cordic_step)
        begin
            x_reg <= x_nx;
            y_reg <= y_nx;
            z_reg <= z_nx;
        end
        if (cmd.do_bend)
            dir_reg <= dir_w;
        if (cmd.rot_mul)
            scale_reg <= 56'({spacing_reg, 8'd0}) * 56'(alcf_pkg::CORDIC_GAIN_Q32);
        if (cmd.rot_init)
        begin
            rot_mode_reg <= 1'b1;
            x_reg        <= CW'(scale_reg >> 16);
            y_reg        <= '0;
            if (zs > 33'sd1073741824 || zs < -33'sd1073741824)
            begin
                flip_reg <= 1'b1;
                z_reg    <= zs[31:0] + 32'h80000000;
            end
            else
            begin
                flip_reg <= 1'b0;
                z_reg    <= zs[31:0];
            end
        end
        if (cmd.out_load && !cmd.out_head)
        begin
            px_reg   <= cx_reg[cmd.seg];
            py_reg   <= cy_reg[cmd.seg];
            pdir_reg <= dir_reg;
            lim_reg  <= spine_lim_reg;
        end
        if (cmd.out_load)
        begin
            if (cmd.out_head)
            begin
                point_index     <= '0;
                point_x         <= hx_reg;
                point_y         <= hy_reg;
                point_direction <= 16'(heading_reg);
                last            <= 1'b0;
            end
            else
            begin
                point_index     <= 4'(cmd.seg) + 4'd1;
                point_x         <= cx_reg[cmd.seg];
                point_y         <= cy_reg[cmd.seg];
                point_direction <= 16'(dir_reg);
                last            <= (cmd.seg == SW'(N - 1));
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hx_reg <= 21'sd7168;
            hy_reg <= 21'sd7168;
            for (int i = 0; i < N; i++)
            begin
                cx_reg[i] <= '0;
                cy_reg[i] <= '0;
            end
        end
        else
        begin
            if (cmd.head_add)
            begin
                hx_reg <= alcf_pkg::sat_coord(CW'(hx_reg) + (mx_reg >>> 8));
                hy_reg <= alcf_pkg::sat_coord(CW'(hy_reg) + (my_reg >>> 8));
            end
            else if (cmd.load_item && jump)
            begin
                hx_reg <= target_x;
                hy_reg <= target_y;
            end
            if (cmd.place)
            begin
                cx_reg[cmd.seg] <= alcf_pkg::sat_coord(CW'(px_reg) - ox_f);
                cy_reg[cmd.seg] <= alcf_pkg::sat_coord(CW'(py_reg) - oy_f);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            point_valid <= 1'b0;
        else if (cmd.out_load)
            point_valid <= 1'b1;
        else if (point_ready)
            point_valid <= 1'b0;
    end

endmodule

### sv/angle_limited_chain_follow_unit.sv
// Top level of the angle-limited chain follow unit.
// The head point comes first, after the head multiply and add states (with jump set, the add state is skipped).
// Each segment runs bearing CORDIC init and iterations, bend clamp, rotation scale, rotation CORDIC, place, output.
// One item at a time: ready is high only in idle, after the last point is output; output stalls hold the sequence.
// Reset: configuration returns to defaults, head to 28 pixels, chain to zero.
module angle_limited_chain_follow_unit (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               valid,
    output logic               ready,
    input  logic signed [20:0] target_x,
    input  logic signed [20:0] target_y,
    input  logic [15:0]        heading,
    input  logic               jump,
    output logic               point_valid,
    input  logic               point_ready,
    output logic [3:0]         point_index,
    output logic signed [20:0] point_x,
    output logic signed [20:0] point_y,
    output logic [15:0]        point_direction,
    output logic               last,
    input  logic               cfg_we,
    input  logic [3:0]         cfg_index,
    input  logic [14:0]        cfg_data
);

    alcf_pkg::cmd_t cmd;
    logic           jump_flag;

    alcf_ctrl u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .valid       (valid),
        .ready       (ready),
        .point_valid (point_valid),
        .point_ready (point_ready),
        .jump_flag   (jump_flag),
        .cmd         (cmd)
    );

    alcf_datapath u_datapath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data),
        .target_x        (target_x),
        .target_y        (target_y),
        .heading         (heading),
        .jump            (jump),
        .jump_flag       (jump_flag),
        .point_index     (point_index),
        .point_x         (point_x),
        .point_y         (point_y),
        .point_direction (point_direction),
        .last            (last),
        .point_valid     (point_valid),
        .point_ready     (point_ready)
    );

endmodule

### tb/testbench.sv
// Testbench for the angle-limited chain follow unit: a local prediction checked against each point.
`timescale 1ns / 1ps

module testbench;

    localparam int NSEG = alcf_pkg::NUM_SEGMENTS;
    localparam int WATCHDOG_LIMIT = 20000;
    localparam logic [31:0] TURN [0:23] = '{
        32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43, 32'h0145D7E1,
        32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
        32'h00028BE6, 32'h000145F3, 32'h0000A2F9, 32'h0000517D, 32'h000028BE, 32'h0000145F,
        32'h00000A30, 32'h00000518, 32'h0000028C, 32'h00000146, 32'h000000A3, 32'h00000051};

    typedef struct packed {
        logic [3:0]         idx;
        logic signed [20:0] x;
        logic signed [20:0] y;
        logic [15:0]        dir;
        logic               tail;
    } point_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic valid = 1'b0;
    logic ready;
    logic signed [20:0] target_x = '0;
    logic signed [20:0] target_y = '0;
    logic [15:0] heading = '0;
    logic jump = 1'b0;
    logic point_valid;
    logic point_ready = 1'b0;
    logic [3:0] point_index;
    logic signed [20:0] point_x;
    logic signed [20:0] point_y;
    logic [15:0] point_direction;
    logic last;
    logic cfg_we = 1'b0;
    logic [3:0] cfg_index = '0;
    logic [14:0] cfg_data = '0;

    angle_limited_chain_follow_unit DUT (.*);

    always #5 clk = ~clk;

    longint spacing, neck_lim, spine_lim, gain;
    longint head_x, head_y;
    longint chain_x [NSEG];
    longint chain_y [NSEG];
    point_t expected_points [$];
    int errors = 0;
    int idle_cycles = 0;
    int stall_cnt = 0;

    function automatic longint clip(longint v);
        if (v > 1048575) return 1048575;
        if (v < -1048576) return -1048576;
        return v;
    endfunction

    function automatic longint shr(longint v, int s);
        return v >>> s;
    endfunction

    function automatic logic [15:0] find_bearing(longint dx, longint dy);
        longint x, y, nx;
        logic [31:0] z;
        z = 32'h0;
        x = dx * 256;
        y = dy * 256;
        if (dx == 0 && dy == 0) return 16'h0;
        if (x < 0)
        begin
            x = -x;
            y = -y;
            z = 32'h80000000;
        end
        for (int i = 0; i < 24; i++)
        begin
            if (y > 0)
            begin
                nx = x + shr(y, i);
                y = y - shr(x, i);
                z = z + TURN[i];
            end
            else
            begin
                nx = x - shr(y, i);
                y = y + shr(x, i);
                z = z - TURN[i];
            end
            x = nx;
        end
        z = z + 32'h8000;
        return z[31:16];
    endfunction

    task automatic spacing_vector(input logic [15:0] a, input longint sp,
                                  output longint ox, output longint oy);
        longint zs, x, y, nx;
        logic [63:0] prod;
        bit flip;
        zs = longint'($signed({a, 16'h0}));
        flip = 0;
        y = 0;
        if (zs > 64'sd1073741824 || zs < -64'sd1073741824)
        begin
            flip = 1;
            zs = zs + ((zs > 0) ? -64'sd2147483648 : 64'sd2147483648);
        end
        prod = 64'(sp) * 64'd256 * 64'd2608131496;
        x = longint'(prod >> 16);
        for (int i = 0; i < 24; i++)
        begin
            if (zs >= 0)
            begin
                nx = x - shr(y, i);
                y = y + shr(x, i);
                zs = zs - longint'(TURN[i]);
            end
            else
            begin
                nx = x + shr(y, i);
                y = y - shr(x, i);
                zs = zs + longint'(TURN[i]);
            end
            x = nx;
        end
        x = shr(x + 32768, 16);
        y = shr(y + 32768, 16);
        ox = flip ? -x : x;
        oy = flip ? -y : y;
    endtask

    function automatic logic [15:0] clamp_bend(logic [15:0] ref_dir, logic [15:0] want,
                                                longint lim);
        longint d;
        logic [15:0] diff;
        diff = want - ref_dir;
        d = longint'(diff);
        if (d > 32768) d = d - 65536;
        if (d > lim) d = lim;
        if (d < -lim) d = -lim;
        return 16'(longint'(ref_dir) + d);
    endfunction

    task automatic predict_chain(input logic signed [20:0] tx, input logic signed [20:0] ty,
                                 input logic [15:0] hd, input logic jp);
        longint px, py, ox, oy, lim;
        logic [15:0] pdir, dir;
        point_t p;
        if (jp)
        begin
            head_x = tx;
            head_y = ty;
        end
        else
        begin
            head_x = clip(head_x + shr((longint'(tx) - head_x) * gain + 128, 8));
            head_y = clip(head_y + shr((longint'(ty) - head_y) * gain + 128, 8));
        end
        p = '{4'd0, 21'(head_x), 21'(head_y), hd, 1'b0};
        expected_points = {expected_points, p};
        px = head_x;
        py = head_y;
        pdir = hd;
        lim = neck_lim;
        for (int i = 0; i < NSEG; i++)
        begin
            dir = clamp_bend(pdir, find_bearing(px - chain_x[i], py - chain_y[i]), lim);
            spacing_vector(dir, spacing, ox, oy);
            chain_x[i] = clip(px - ox);
            chain_y[i] = clip(py - oy);
            p = '{4'(i + 1), 21'(chain_x[i]), 21'(chain_y[i]), dir, i == NSEG - 1};
            expected_points = {expected_points, p};
            px = chain_x[i];
            py = chain_y[i];
            pdir = dir;
            lim = spine_lim;
        end
    endtask

    task automatic send_item(input logic signed [20:0] tx, input logic signed [20:0] ty,
                             input logic [15:0] hd, input logic jp);
        int gap;
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 12);
        if (gap > 0)
        begin
            valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        valid <= 1'b1;
        target_x <= tx;
        target_y <= ty;
        heading <= hd;
        jump <= jp;
        @(posedge clk);
        while (!ready) @(posedge clk);
        predict_chain(tx, ty, hd, jp);
    endtask

    task automatic wait_drain();
        valid <= 1'b0;
        while (expected_points.size() != 0) @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic write_reg(input logic [3:0] idx, input longint value);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= 15'(value);
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            alcf_pkg::REG_SPACING: spacing = value & 8'hFF;
            alcf_pkg::REG_NECK:    neck_lim = value & 15'h7FFF;
            alcf_pkg::REG_SPINE:   spine_lim = value & 15'h7FFF;
            alcf_pkg::REG_GAIN:    gain = value & 9'h1FF;
            default: ;
        endcase
        @(posedge clk);
    endtask

    function automatic logic signed [20:0] rand_coord();
        case ($urandom_range(0, 5))
            0: return -21'sd1048576;
            1: return 21'sd1048575;
            2: return 21'($urandom);
            default: return 21'(int'($urandom_range(0, 40000)) - 20000);
        endcase
    endfunction

    task automatic random_items(input int n);
        for (int i = 0; i < n; i++)
            send_item(rand_coord(), rand_coord(), 16'($urandom), $urandom_range(0, 3) == 0);
    endtask

    task automatic test_defaults();
        send_item(21'sd0, 21'sd0, 16'd0, 1'b0);
        send_item(21'sd7168, 21'sd7168, 16'd16384, 1'b0);
        send_item(21'sd1048575, 21'sd1048575, 16'hFFFF, 1'b1);
        send_item(-21'sd1048576, -21'sd1048576, 16'h8000, 1'b1);
        send_item(-21'sd1048576, 21'sd1048575, 16'h7FFF, 1'b0);
        send_item(21'sd5000, -21'sd5000, 16'h4000, 1'b1);
        send_item(21'sd5000, -21'sd5000, 16'hC000, 1'b1);
        wait_drain();
    endtask

    task automatic test_extremes();
        write_reg(alcf_pkg::REG_SPACING, 0);
        write_reg(alcf_pkg::REG_NECK, 16384);
        write_reg(alcf_pkg::REG_SPINE, 0);
        write_reg(alcf_pkg::REG_GAIN, 256);
        send_item(21'sd100, 21'sd100, 16'd0, 1'b0);
        send_item(21'sd100, 21'sd100, 16'h8000, 1'b1);
        wait_drain();
        write_reg(alcf_pkg::REG_SPACING, 255);
        write_reg(alcf_pkg::REG_NECK, 0);
        write_reg(alcf_pkg::REG_SPINE, 16384);
        write_reg(alcf_pkg::REG_GAIN, 511);
        send_item(21'sd1048575, -21'sd1048576, 16'h1234, 1'b0);
        send_item(21'sd1048000, 21'sd1048000, 16'hEDCB, 1'b1);
        send_item(-21'sd1048000, 21'sd0, 16'h0001, 1'b0);
        wait_drain();
        write_reg(alcf_pkg::REG_NECK, 32767);
        write_reg(alcf_pkg::REG_SPINE, 32767);
        write_reg(alcf_pkg::REG_GAIN, 0);
        send_item(21'sd300, 21'sd300, 16'h5555, 1'b0);
        send_item(21'sd300, 21'sd300, 16'hAAAA, 1'b1);
        wait_drain();
    endtask

    task automatic test_random_settings();
        for (int phase = 0; phase < 6; phase++)
        begin
            write_reg(alcf_pkg::REG_SPACING, $urandom_range(1, 255));
            write_reg(alcf_pkg::REG_NECK, $urandom_range(0, 16384));
            write_reg(alcf_pkg::REG_SPINE, $urandom_range(0, 16384));
            write_reg(alcf_pkg::REG_GAIN, $urandom_range(0, 256));
            random_items(55);
            wait_drain();
        end
        write_reg(alcf_pkg::REG_SPACING, 35);
        write_reg(alcf_pkg::REG_NECK, 3095);
        write_reg(alcf_pkg::REG_SPINE, 5643);
        write_reg(alcf_pkg::REG_GAIN, 51);
        random_items(15);
        wait_drain();
    endtask

    always @(posedge clk)
    begin
        int stall_n;
        if (rst_n)
        begin
            if (point_valid && point_ready)
            begin
                stall_n = $urandom_range(0, 12);
                stall_cnt <= stall_n;
                point_ready <= (stall_n == 0);
            end
            else if (stall_cnt > 0)
            begin
                stall_cnt <= stall_cnt - 1;
                point_ready <= (stall_cnt == 1);
            end
            else
                point_ready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        point_t e;
        if (rst_n && point_valid && point_ready)
        begin
            if (expected_points.size() == 0)
            begin
                $display("%0t: unexpected point index %0d", $time, point_index);
                errors++;
            end
            else
            begin
                e = expected_points.pop_front();
                if (e.idx !== point_index || e.x !== point_x || e.y !== point_y ||
                    e.dir !== point_direction || e.tail !== last)
                begin
                    $display("%0t: mismatch expected idx %0d x %0d y %0d dir %0d last %0d",
                             $time, e.idx, e.x, e.y, e.dir, e.tail);
                    $display("%0t:          actual   idx %0d x %0d y %0d dir %0d last %0d",
                             $time, point_index, point_x, point_y, point_direction, last);
                    errors++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((valid && ready) || (point_valid && point_ready) || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    initial
    begin
        spacing = 35;
        neck_lim = 3095;
        spine_lim = 5643;
        gain = 51;
        head_x = 7168;
        head_y = 7168;
        for (int i = 0; i < NSEG; i++)
        begin
            chain_x[i] = 0;
            chain_y[i] = 0;
        end
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_defaults();
        test_extremes();
        test_random_settings();
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
